// ----- rtl/tcf_pkg.sv -----
// Shared constants, types and the CRC byte step for the tag reader command framer.
package tcf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT = 16'h0000;

  localparam logic [BYTE_W-1:0] ADDR_ALL  = 8'hff;
  localparam logic [BYTE_W-1:0] WRITE_LEN = 8'h0b;
  localparam logic [BYTE_W-1:0] READ_LEN  = 8'h06;
  localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_READ  = 8'h12;
  localparam logic [BYTE_W-1:0] LOCK_NONE = 8'h00;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register byte addresses.
  localparam logic [CFG_ADDR_W-1:0] REG_MODULE_ADDRESS = 3'd0;

  // Byte positions within a frame.
  localparam logic [IDX_W-1:0] POS_ADDR  = 4'd0;
  localparam logic [IDX_W-1:0] POS_LEN   = 4'd1;
  localparam logic [IDX_W-1:0] POS_CMD   = 4'd2;
  localparam logic [IDX_W-1:0] POS_D1    = 4'd3;
  localparam logic [IDX_W-1:0] POS_D2    = 4'd4;
  localparam logic [IDX_W-1:0] POS_D3    = 4'd5;
  localparam logic [IDX_W-1:0] POS_D4    = 4'd6;
  localparam logic [IDX_W-1:0] POS_SECT  = 4'd7;
  localparam logic [IDX_W-1:0] POS_LOCK  = 4'd8;
  localparam logic [IDX_W-1:0] WRITE_LAST = 4'd10;
  localparam logic [IDX_W-1:0] READ_LAST  = 4'd5;

  typedef struct packed {
    logic              clear;
    logic              update;
    logic [BYTE_W-1:0] data;
  } crc_ctl_t;

  function automatic logic [CRC_W-1:0] crc16_add(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/tcf_crc16.sv -----
// Running CRC-16 register, advanced by one frame byte per cycle while update is set.
module tcf_crc16 (
  input  logic                        clk,
  input  tcf_pkg::crc_ctl_t           ctl,
  output logic [tcf_pkg::CRC_W-1:0]   crc
);
  import tcf_pkg::*;

  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clear) begin
      crc_nxt = CRC_INIT;
    end else if (ctl.update) begin
      crc_nxt = crc16_add(crc_r, ctl.data);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

// ----- rtl/tag_reader_command_framer_core.sv -----
// Top level of the tag reader command framer: command capture, byte sequencing, APB register.
// After start is taken, the first frame byte passes the frame position and result registers.
// One frame byte per cycle; a write frame holds 11 bytes, a read frame 6.
// busy drops during the cycle that selects a frame's last byte, so frames follow without gaps.
// The frame position counter and the one-byte-per-cycle CRC step set that rate.
// Reset (rst_n low, synchronous) stops any frame, clears out_valid and sets module_address to 255.
module tag_reader_command_framer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_op,
  input  logic [tcf_pkg::BYTE_W-1:0]         in_data_first,
  input  logic [tcf_pkg::BYTE_W-1:0]         in_data_second,
  input  logic [tcf_pkg::BYTE_W-1:0]         in_data_third,
  input  logic [tcf_pkg::BYTE_W-1:0]         in_data_fourth,
  input  logic [tcf_pkg::BYTE_W-1:0]         in_sector,
  output logic                               out_valid,
  output logic [tcf_pkg::BYTE_W-1:0]         out_frame_byte,
  output logic                               out_last_byte,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import tcf_pkg::*;

  logic              addr_hit;
  logic [BYTE_W-1:0] mod_addr_r;
  logic              active_r, active_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              op_r;
  logic [BYTE_W-1:0] d1_r, d2_r, d3_r, d4_r, sector_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic              accept;
  logic              at_last;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  crc_hi_idx;
  logic [BYTE_W-1:0] body_byte;
  logic [BYTE_W-1:0] byte_sel;
  logic [CRC_W-1:0]  crc;
  crc_ctl_t          crc_ctl;

  // Configuration port.
  assign pready   = 1'b1;
  assign addr_hit = (paddr == REG_MODULE_ADDRESS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_addr_r <= ADDR_ALL;
    end else if (psel && penable && pwrite && pready && addr_hit) begin
      mod_addr_r <= pwdata[BYTE_W-1:0];
    end
  end

  assign prdata = addr_hit ? {{(32-BYTE_W){1'b0}}, mod_addr_r} : 32'd0;

  // Frame sequencing.
  assign last_idx   = (op_r == OP_READ) ? READ_LAST : WRITE_LAST;
  assign crc_hi_idx = last_idx - 4'd1;
  assign at_last    = active_r && (idx_r == last_idx);
  assign busy       = active_r && !at_last;
  assign accept     = start && !busy;

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (accept) begin
      active_nxt = 1'b1;
      idx_nxt    = POS_ADDR;
    end else if (at_last) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= POS_ADDR;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      d1_r     <= in_data_first;
      d2_r     <= in_data_second;
      d3_r     <= in_data_third;
      d4_r     <= in_data_fourth;
      sector_r <= in_sector;
    end
  end

  // A read frame carries the sector where a write frame carries its first data byte.
  always_comb begin
    case (idx_r)
      POS_ADDR: body_byte = mod_addr_r;
      POS_LEN:  body_byte = (op_r == OP_READ) ? READ_LEN : WRITE_LEN;
      POS_CMD:  body_byte = (op_r == OP_READ) ? CMD_READ : CMD_WRITE;
      POS_D1:   body_byte = (op_r == OP_READ) ? sector_r : d1_r;
      POS_D2:   body_byte = d2_r;
      POS_D3:   body_byte = d3_r;
      POS_D4:   body_byte = d4_r;
      POS_SECT: body_byte = sector_r;
      POS_LOCK: body_byte = LOCK_NONE;
      default:  body_byte = LOCK_NONE;
    endcase
  end

  // The CRC register already holds every body byte by the time its high byte is selected.
  always_comb begin
    if (idx_r == crc_hi_idx) begin
      byte_sel = crc[CRC_W-1:BYTE_W];
    end else if (idx_r == last_idx) begin
      byte_sel = crc[BYTE_W-1:0];
    end else begin
      byte_sel = body_byte;
    end
  end

  assign crc_ctl.clear  = accept;
  assign crc_ctl.update = active_r && (idx_r < crc_hi_idx);
  assign crc_ctl.data   = body_byte;

  tcf_crc16 u_crc (
    .clk (clk),
    .ctl (crc_ctl),
    .crc (crc)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= active_r;
      out_last_r  <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= byte_sel;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_byte |-> out_valid)
    else $error("last byte marker without a valid byte");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the framer busy");

  a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_byte) |=> out_valid)
    else $error("frame interrupted before its last byte");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("byte strobe right after reset");

endmodule
